[hw/rtl/box_blur_3x3_edge_average_macros.svh]
// assertion helpers shared by the blur block
`ifndef BOX_BLUR_3X3_EDGE_AVERAGE_MACROS_SVH
`define BOX_BLUR_3X3_EDGE_AVERAGE_MACROS_SVH

// same-cycle implication, checked outside reset
`define BBEA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("blur assertion failed");

// next-cycle implication, checked outside reset
`define BBEA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("blur assertion failed");

`endif

[hw/rtl/bbea_pkg.sv]
`default_nettype none
package bbea_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int DIM_W      = 11;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int CH_W       = 8;
  localparam int PIX_W      = 3 * CH_W;
  localparam int SUM_W      = 12;
  localparam int CNT_W      = 4;
  localparam int RECIP_W    = 20;
  localparam int NUM_W      = SUM_W + 1;
  localparam int PROD_W     = NUM_W + RECIP_W;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);

  typedef struct packed {
    logic       accept;
    logic       load;
    logic       capture;
    logic       divide;
    logic [1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic [3:0] combo_ok;
  } status_t;

  // ceil(2^20 / (2*count)), exact for every numerator the sums can reach
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
    logic [RECIP_W-1:0] m;
    case (cnt)
      4'd1:    m = RECIP_W'(524288);
      4'd2:    m = RECIP_W'(262144);
      4'd3:    m = RECIP_W'(174763);
      4'd4:    m = RECIP_W'(131072);
      4'd6:    m = RECIP_W'(87382);
      4'd9:    m = RECIP_W'(58255);
      default: m = RECIP_W'(524288);
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/bbea_ram.sv]
`default_nettype none
module bbea_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[hw/rtl/bbea_ctrl.sv]
`default_nettype none
module bbea_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  input  wire bbea_pkg::status_t status,
  output bbea_pkg::cmd_t         cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_LOAD   = 5'b00010,
    S_SCAN   = 5'b00100,
    S_DIVIDE = 5'b01000,
    S_EMIT   = 5'b10000
  } state_t;

  state_t     state, state_next;
  logic [1:0] idx, idx_next;

  always_comb begin
    state_next  = state;
    idx_next    = idx;
    cmd.accept  = 1'b0;
    cmd.load    = 1'b0;
    cmd.capture = 1'b0;
    cmd.divide  = 1'b0;
    cmd.idx     = idx;
    in_stall    = 1'b1;
    out_valid   = 1'b0;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load   = 1'b1;
        idx_next   = 2'd0;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        // walk the four row/column combos in raster order, skipping absent ones
        if (status.combo_ok[idx]) begin
          cmd.capture = 1'b1;
          state_next  = S_DIVIDE;
        end else if (idx == 2'd3) begin
          state_next = S_IDLE;
        end else begin
          idx_next = idx + 2'd1;
        end
      end
      S_DIVIDE: begin
        cmd.divide = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          if (idx == 2'd3) begin
            state_next = S_IDLE;
          end else begin
            idx_next   = idx + 2'd1;
            state_next = S_SCAN;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= 2'd0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/bbea_dp.sv]
`default_nettype none
module bbea_dp (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire bbea_pkg::cmd_t               cmd,
  output bbea_pkg::status_t                 status,
  input  wire logic                         cfg_write,
  input  wire logic                         cfg_index,
  input  wire logic [bbea_pkg::DIM_W-1:0]   cfg_data,
  input  wire logic [bbea_pkg::CH_W-1:0]    red,
  input  wire logic [bbea_pkg::CH_W-1:0]    green,
  input  wire logic [bbea_pkg::CH_W-1:0]    blue,
  output logic      [bbea_pkg::CH_W-1:0]    out_red,
  output logic      [bbea_pkg::CH_W-1:0]    out_green,
  output logic      [bbea_pkg::CH_W-1:0]    out_blue,
  output logic      [9:0]                   out_row,
  output logic      [9:0]                   out_col,
  output logic                              frame_last
);

  localparam int DW = bbea_pkg::DIM_W;
  localparam int CW = bbea_pkg::COL_W;
  localparam int RW = bbea_pkg::ROW_W;
  localparam int PW = bbea_pkg::PIX_W;
  localparam int SW = bbea_pkg::SUM_W;
  localparam int NW = bbea_pkg::CNT_W;

  logic [DW-1:0] width_reg, height_reg;
  logic [DW-1:0] w_eff, h_eff;
  logic [CW-1:0] col_cnt, cur_j;
  logic [RW-1:0] row_cnt, cur_i;
  logic [PW-1:0] pix_reg;
  logic [PW-1:0] win [3][3];
  logic [2*PW-1:0] ram_rdata;
  logic [SW-1:0] sum_r, sum_g, sum_b;
  logic [SW-1:0] sum_r_next, sum_g_next, sum_b_next;
  logic [NW-1:0] cnt, cnt_next;
  logic [RW-1:0] pos_r, pos_r_next;
  logic [CW-1:0] pos_c, pos_c_next;
  logic          last, last_next;
  logic [2:0]    rmask, cmask;
  logic [1:0]    nrows, ncols;
  logic [1:0]    row_ok, col_ok;
  logic          rsel, csel;
  logic          col_wrap, row_wrap;
  logic [bbea_pkg::RECIP_W-1:0] m;
  logic [bbea_pkg::NUM_W-1:0]   num_r, num_g, num_b;
  logic [bbea_pkg::PROD_W-1:0]  prod_r, prod_g, prod_b;

  // zero means one, anything past the line store saturates
  always_comb begin
    if (width_reg == '0) begin
      w_eff = DW'(1);
    end else if (width_reg > DW'(bbea_pkg::MAX_WIDTH)) begin
      w_eff = DW'(bbea_pkg::MAX_WIDTH);
    end else begin
      w_eff = width_reg;
    end
    if (height_reg == '0) begin
      h_eff = DW'(1);
    end else if (height_reg > DW'(bbea_pkg::MAX_HEIGHT)) begin
      h_eff = DW'(bbea_pkg::MAX_HEIGHT);
    end else begin
      h_eff = height_reg;
    end
  end

  // one entry holds {row i-2, row i-1} of a column
  bbea_ram #(
    .WIDTH(2 * PW),
    .DEPTH(bbea_pkg::MAX_WIDTH)
  ) u_lines (
    .clk  (clk),
    .we   (cmd.load),
    .waddr(col_cnt),
    .wdata({ram_rdata[PW-1:0], pix_reg}),
    .raddr(col_cnt),
    .rdata(ram_rdata)
  );

  assign col_wrap = ((DW'(col_cnt) + DW'(1)) >= w_eff);
  assign row_wrap = ((DW'(row_cnt) + DW'(1)) >= h_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= bbea_pkg::WIDTH_RESET;
      height_reg <= bbea_pkg::HEIGHT_RESET;
      col_cnt    <= '0;
      row_cnt    <= '0;
    end else if (cfg_write) begin
      if (cfg_index == bbea_pkg::REG_WIDTH) begin
        width_reg <= cfg_data;
      end else begin
        height_reg <= cfg_data;
      end
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (cmd.load) begin
      if (col_wrap) begin
        col_cnt <= '0;
        row_cnt <= row_wrap ? '0 : row_cnt + RW'(1);
      end else begin
        col_cnt <= col_cnt + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pix_reg <= {red, green, blue};
    end
    if (cmd.load) begin
      cur_i <= row_cnt;
      cur_j <= col_cnt;
      for (int k = 0; k < 3; k++) begin
        win[k][0] <= win[k][1];
        win[k][1] <= win[k][2];
      end
      win[0][2] <= ram_rdata[2*PW-1:PW];
      win[1][2] <= ram_rdata[PW-1:0];
      win[2][2] <= pix_reg;
    end
  end

  assign row_ok[0] = (cur_i != '0);
  assign row_ok[1] = (DW'(cur_i) == h_eff - DW'(1));
  assign col_ok[0] = (cur_j != '0);
  assign col_ok[1] = (DW'(cur_j) == w_eff - DW'(1));

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      status.combo_ok[k] = row_ok[k / 2] & col_ok[k % 2];
    end
  end

  assign rsel = cmd.idx[1];
  assign csel = cmd.idx[0];

  // window row k holds image row i-2+k; keep rows inside the image and near r
  assign rmask[0] = !rsel && (cur_i >= RW'(2));
  assign rmask[1] = (cur_i >= RW'(1));
  assign rmask[2] = 1'b1;
  assign cmask[0] = !csel && (cur_j >= CW'(2));
  assign cmask[1] = (cur_j >= CW'(1));
  assign cmask[2] = 1'b1;

  assign nrows = {1'b0, rmask[0]} + {1'b0, rmask[1]} + {1'b0, rmask[2]};
  assign ncols = {1'b0, cmask[0]} + {1'b0, cmask[1]} + {1'b0, cmask[2]};
  assign cnt_next = NW'({2'b00, nrows} * {2'b00, ncols});

  always_comb begin
    sum_r_next = '0;
    sum_g_next = '0;
    sum_b_next = '0;
    for (int k = 0; k < 3; k++) begin
      for (int n = 0; n < 3; n++) begin
        if (rmask[k] && cmask[n]) begin
          sum_r_next = sum_r_next + SW'(win[k][n][PW-1:2*bbea_pkg::CH_W]);
          sum_g_next = sum_g_next + SW'(win[k][n][2*bbea_pkg::CH_W-1:bbea_pkg::CH_W]);
          sum_b_next = sum_b_next + SW'(win[k][n][bbea_pkg::CH_W-1:0]);
        end
      end
    end
  end

  assign pos_r_next = rsel ? cur_i : cur_i - RW'(1);
  assign pos_c_next = csel ? cur_j : cur_j - CW'(1);
  assign last_next  = (DW'(pos_r_next) == h_eff - DW'(1))
                   && (DW'(pos_c_next) == w_eff - DW'(1));

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sum_r <= sum_r_next;
      sum_g <= sum_g_next;
      sum_b <= sum_b_next;
      cnt   <= cnt_next;
      pos_r <= pos_r_next;
      pos_c <= pos_c_next;
      last  <= last_next;
    end
  end

  // rounded mean: (2*sum + cnt) / (2*cnt) by reciprocal multiply
  assign m      = bbea_pkg::recip(cnt);
  assign num_r  = {sum_r, 1'b0} + bbea_pkg::NUM_W'(cnt);
  assign num_g  = {sum_g, 1'b0} + bbea_pkg::NUM_W'(cnt);
  assign num_b  = {sum_b, 1'b0} + bbea_pkg::NUM_W'(cnt);
  assign prod_r = bbea_pkg::PROD_W'(num_r) * bbea_pkg::PROD_W'(m);
  assign prod_g = bbea_pkg::PROD_W'(num_g) * bbea_pkg::PROD_W'(m);
  assign prod_b = bbea_pkg::PROD_W'(num_b) * bbea_pkg::PROD_W'(m);

  always_ff @(posedge clk) begin
    if (cmd.divide) begin
      out_red    <= prod_r[bbea_pkg::RECIP_W+bbea_pkg::CH_W-1:bbea_pkg::RECIP_W];
      out_green  <= prod_g[bbea_pkg::RECIP_W+bbea_pkg::CH_W-1:bbea_pkg::RECIP_W];
      out_blue   <= prod_b[bbea_pkg::RECIP_W+bbea_pkg::CH_W-1:bbea_pkg::RECIP_W];
      out_row    <= pos_r[9:0];
      out_col    <= pos_c[9:0];
      frame_last <= last;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/box_blur_3x3_edge_average.sv]
// 3x3 box blur with edge-aware averaging over a raster rgb stream
// each pixel beat is accepted, read against the line store, then scanned once per
// row/column combo (sums taken there); each result adds a divide step and an output beat
// no new pixel is taken until every result of the last one has left the output
// rst clears the controller and position counters and sets width 640, height 480
`default_nettype none
`include "box_blur_3x3_edge_average_macros.svh"
module box_blur_3x3_edge_average (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_write,
  input  wire logic                       cfg_index,
  input  wire logic [bbea_pkg::DIM_W-1:0] cfg_data,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [bbea_pkg::CH_W-1:0]  red,
  input  wire logic [bbea_pkg::CH_W-1:0]  green,
  input  wire logic [bbea_pkg::CH_W-1:0]  blue,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic      [bbea_pkg::CH_W-1:0]  out_red,
  output logic      [bbea_pkg::CH_W-1:0]  out_green,
  output logic      [bbea_pkg::CH_W-1:0]  out_blue,
  output logic      [9:0]                 out_row,
  output logic      [9:0]                 out_col,
  output logic                            frame_last
);

  bbea_pkg::cmd_t    cmd;
  bbea_pkg::status_t status;

  bbea_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status   (status),
    .cmd      (cmd)
  );

  bbea_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .out_row   (out_row),
    .out_col   (out_col),
    .frame_last(frame_last)
  );

  // a result beat is only offered while no pixel can enter
  `BBEA_ASSERT_NOW(a_out_blocks_in, out_valid, in_stall)
  // the cycle after a pixel beat is the line store read, never a result
  `BBEA_ASSERT_NEXT(a_accept_then_load, in_valid && !in_stall, !out_valid && in_stall)
  // each result is a single beat followed by a new scan or idle
  `BBEA_ASSERT_NEXT(a_one_beat, out_valid && !out_stall, !out_valid)

endmodule
`default_nettype wire

[bench/box_blur_3x3_edge_average_tb.sv]
`default_nettype none
module box_blur_3x3_edge_average_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [bbea_pkg::CH_W-1:0] red;
    logic [bbea_pkg::CH_W-1:0] green;
    logic [bbea_pkg::CH_W-1:0] blue;
    logic [9:0]                row;
    logic [9:0]                col;
    logic                      last;
  } blur_px_t;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int HOLD_CYCLES    = 300;

  class blur_scoreboard;
    int unsigned                width_reg;
    int unsigned                height_reg;
    logic [bbea_pkg::PIX_W-1:0] older_line[bbea_pkg::MAX_WIDTH];
    logic [bbea_pkg::PIX_W-1:0] newer_line[bbea_pkg::MAX_WIDTH];
    logic [bbea_pkg::PIX_W-1:0] win[3][3];
    int                         row_pos;
    int                         col_pos;
    blur_px_t                   expected_q[$];
    int                         failures;

    function new();
      width_reg  = 640;
      height_reg = 480;
      row_pos    = 0;
      col_pos    = 0;
      failures   = 0;
      foreach (win[a, b]) win[a][b] = '0;
      foreach (older_line[a]) begin
        older_line[a] = '0;
        newer_line[a] = '0;
      end
    endfunction

    function void write_dim(logic idx, logic [bbea_pkg::DIM_W-1:0] val);
      if (idx == bbea_pkg::REG_WIDTH) width_reg = val;
      else height_reg = val;
      row_pos = 0;
      col_pos = 0;
    endfunction

    function int clamp_dim(int unsigned v, int unsigned maxv);
      if (v == 0) return 1;
      return (v > maxv) ? maxv : v;
    endfunction

    // mean of the in-bounds neighbors that have arrived, rounded half up
    function blur_px_t average_at(int r, int c, int i, int j, int h, int w);
      blur_px_t res;
      int sr, sg, sb, cnt;
      logic [bbea_pkg::PIX_W-1:0] p;
      sr = 0; sg = 0; sb = 0; cnt = 0;
      for (int x = r - 1; x <= r + 1; x++) begin
        if (x < 0 || x >= h || x > i) continue;
        for (int y = c - 1; y <= c + 1; y++) begin
          if (y < 0 || y >= w || y > j) continue;
          p = win[x - i + 2][y - j + 2];
          sr += p[23:16];
          sg += p[15:8];
          sb += p[7:0];
          cnt++;
        end
      end
      if (cnt == 0) cnt = 1;
      res.red   = bbea_pkg::CH_W'((2 * sr + cnt) / (2 * cnt));
      res.green = bbea_pkg::CH_W'((2 * sg + cnt) / (2 * cnt));
      res.blue  = bbea_pkg::CH_W'((2 * sb + cnt) / (2 * cnt));
      res.row   = 10'(r);
      res.col   = 10'(c);
      res.last  = (r == h - 1 && c == w - 1);
      return res;
    endfunction

    function void note_pixel(logic [bbea_pkg::CH_W-1:0] r, logic [bbea_pkg::CH_W-1:0] g,
                             logic [bbea_pkg::CH_W-1:0] b);
      int w, h, i, j;
      logic [bbea_pkg::PIX_W-1:0] pix, above2, above1;
      int rows[$];
      int cols[$];
      w = clamp_dim(width_reg, bbea_pkg::MAX_WIDTH);
      h = clamp_dim(height_reg, bbea_pkg::MAX_HEIGHT);
      pix = {r, g, b};
      if (row_pos >= h || col_pos >= w) begin
        row_pos = 0;
        col_pos = 0;
      end
      i = row_pos;
      j = col_pos;
      above2 = older_line[j];
      above1 = newer_line[j];
      older_line[j] = above1;
      newer_line[j] = pix;
      for (int k = 0; k < 3; k++) begin
        win[k][0] = win[k][1];
        win[k][1] = win[k][2];
      end
      win[0][2] = above2;
      win[1][2] = above1;
      win[2][2] = pix;
      if (i >= 1) rows.push_back(i - 1);
      if (i == h - 1) rows.push_back(i);
      if (j >= 1) cols.push_back(j - 1);
      if (j == w - 1) cols.push_back(j);
      foreach (rows[k])
        foreach (cols[m])
          expected_q.push_back(average_at(rows[k], cols[m], i, j, h, w));
      col_pos++;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
        if (row_pos >= h) row_pos = 0;
      end
    endfunction

    function void compare_field(string name, int unsigned exp, int unsigned got);
      if (exp != got) begin
        $display("%0t: %s mismatch, expected %0d actual %0d", $realtime, name, exp, got);
        failures++;
      end
    endfunction

    function void check_result(blur_px_t got);
      blur_px_t exp;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected beat, expected none actual row %0d col %0d",
                 $realtime, got.row, got.col);
        failures++;
        return;
      end
      exp = expected_q.pop_front();
      compare_field("out_red", exp.red, got.red);
      compare_field("out_green", exp.green, got.green);
      compare_field("out_blue", exp.blue, got.blue);
      compare_field("out_row", exp.row, got.row);
      compare_field("out_col", exp.col, got.col);
      compare_field("frame_last", exp.last, got.last);
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_write = 1'b0;
  logic                       cfg_index = bbea_pkg::REG_WIDTH;
  logic [bbea_pkg::DIM_W-1:0] cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [bbea_pkg::CH_W-1:0]  red = '0;
  logic [bbea_pkg::CH_W-1:0]  green = '0;
  logic [bbea_pkg::CH_W-1:0]  blue = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [bbea_pkg::CH_W-1:0]  out_red;
  logic [bbea_pkg::CH_W-1:0]  out_green;
  logic [bbea_pkg::CH_W-1:0]  out_blue;
  logic [9:0]                 out_row;
  logic [9:0]                 out_col;
  logic                       frame_last;

  blur_scoreboard blur_sb = new();
  idle_mode_t     idle_mode = IDLE_NONE;
  bit             hold_req = 1'b0;
  int             hold_left = 0;
  int             quiet_cycles = 0;

  box_blur_3x3_edge_average dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .red(red), .green(green), .blue(blue),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .out_row(out_row), .out_col(out_col), .frame_last(frame_last)
  );

  always #6 clk = ~clk;

  function int idle_percent();
    case (idle_mode)
      IDLE_NONE: return 0;
      IDLE_BOTH: return 29;
      default:   return 51;
    endcase
  endfunction

  // receiver side: random stall, or a long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall = 1'b1;
    end else if (idle_mode == IDLE_RECEIVER || idle_mode == IDLE_BOTH) begin
      out_stall = ($urandom_range(0, 99) < idle_percent());
    end else begin
      out_stall = 1'b0;
    end
  end

  always @(posedge clk) begin
    blur_px_t got;
    if (!rst) begin
      if (in_valid && !in_stall) blur_sb.note_pixel(red, green, blue);
      if (out_valid && !out_stall) begin
        got.red   = out_red;
        got.green = out_green;
        got.blue  = out_blue;
        got.row   = out_row;
        got.col   = out_col;
        got.last  = frame_last;
        blur_sb.check_result(got);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog, no beat for %0d cycles", $realtime, quiet_cycles);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic send_pixel(logic [bbea_pkg::CH_W-1:0] r, logic [bbea_pkg::CH_W-1:0] g,
                            logic [bbea_pkg::CH_W-1:0] b);
    if (idle_mode == IDLE_SENDER || idle_mode == IDLE_BOTH) begin
      while ($urandom_range(0, 99) < idle_percent()) begin
        in_valid = 1'b0;
        @(negedge clk);
      end
    end
    in_valid = 1'b1;
    red = r;
    green = g;
    blue = b;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (blur_sb.expected_q.size() != 0) @(posedge clk);
    // a pixel with no result may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_dims(int unsigned w, int unsigned h);
    cfg_write = 1'b1;
    cfg_index = bbea_pkg::REG_WIDTH;
    cfg_data = bbea_pkg::DIM_W'(w);
    @(negedge clk);
    cfg_index = bbea_pkg::REG_HEIGHT;
    cfg_data = bbea_pkg::DIM_W'(h);
    @(negedge clk);
    cfg_write = 1'b0;
    blur_sb.write_dim(bbea_pkg::REG_WIDTH, bbea_pkg::DIM_W'(w));
    blur_sb.write_dim(bbea_pkg::REG_HEIGHT, bbea_pkg::DIM_W'(h));
  endtask

  task automatic send_random(int n);
    repeat (n) send_pixel(bbea_pkg::CH_W'($urandom), bbea_pkg::CH_W'($urandom),
                          bbea_pkg::CH_W'($urandom));
  endtask

  initial begin
    logic [bbea_pkg::CH_W-1:0] pattern[4];
    pattern = '{8'hff, 8'h00, 8'haa, 8'h55};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset size: no result before row 1
    idle_mode = IDLE_NONE;
    for (int k = 0; k < 4; k++) send_pixel(pattern[k], pattern[3 - k], pattern[k]);
    drain();

    // 3x3 frame covers neighbor counts 4, 6 and 9
    set_dims(3, 3);
    for (int k = 0; k < 9; k++) send_pixel(pattern[k % 4], pattern[(k + 1) % 4], pattern[(k + 2) % 4]);
    drain();
    set_dims(1, 1);
    send_pixel(8'hff, 8'hff, 8'hff);
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'h01, 8'hfe, 8'h80);
    drain();
    // zero size acts as one
    set_dims(0, 0);
    send_pixel(8'h7f, 8'h80, 8'h01);
    send_pixel(8'h00, 8'hff, 8'h00);
    drain();
    // oversize saturates
    set_dims(2047, 2047);
    send_pixel(8'hff, 8'h00, 8'hff);
    send_pixel(8'h00, 8'hff, 8'h00);
    drain();
    set_dims(1024, 1024);
    send_pixel(8'h55, 8'haa, 8'h55);
    drain();

    idle_mode = IDLE_SENDER;
    set_dims(4, 4);
    send_random(32);
    drain();
    idle_mode = IDLE_RECEIVER;
    set_dims(5, 3);
    send_random(30);
    drain();
    idle_mode = IDLE_BOTH;
    set_dims($urandom_range(1, 6), $urandom_range(1, 5));
    send_random(25);
    drain();

    // long hold-off on the output while pixels keep coming
    idle_mode = IDLE_NONE;
    set_dims(3, 40);
    @(posedge clk);
    hold_req = 1'b1;
    @(negedge clk);
    send_random(22);
    drain();

    if (blur_sb.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire

[box_blur_3x3_edge_average.f]
+incdir+hw/rtl
hw/rtl/bbea_pkg.sv
hw/rtl/bbea_ram.sv
hw/rtl/bbea_ctrl.sv
hw/rtl/bbea_dp.sv
hw/rtl/box_blur_3x3_edge_average.sv
bench/box_blur_3x3_edge_average_tb.sv
